@@ hdl/ewr_pkg.sv @@
// ----------------------------------------------------------------------------
// ewr_pkg
// Shared types and constants for the e-paper window refresh sequencer.
// ----------------------------------------------------------------------------
package ewr_pkg;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_WAIT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_PANEL_READY     = 3'd0,
		REG_FORCE_FULL      = 3'd1,
		REG_FULL_TIMEOUT    = 3'd2,
		REG_PARTIAL_TIMEOUT = 3'd3,
		REG_UPDATE_CTRL     = 3'd4,
		REG_ACTIVATION      = 3'd5
	} reg_idx_t;

	// panel command and data bytes
	localparam logic [7:0] CMD_ENTRY_MODE    = 8'h11;
	localparam logic [7:0] ENTRY_XY_INC      = 8'h03;
	localparam logic [7:0] CMD_RAM_X_WINDOW  = 8'h44;
	localparam logic [7:0] CMD_RAM_Y_WINDOW  = 8'h45;
	localparam logic [7:0] CMD_RAM_X_PTR     = 8'h4e;
	localparam logic [7:0] CMD_RAM_Y_PTR     = 8'h4f;
	localparam logic [7:0] UPDATE_PARTIAL    = 8'hfc;
	localparam logic [7:0] UPDATE_FULL       = 8'hf7;

	// register reset values
	localparam logic [15:0] FULL_TIMEOUT_RST    = 16'd3000;
	localparam logic [15:0] PARTIAL_TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  UPDATE_CTRL_RST     = 8'h22;
	localparam logic [7:0]  ACTIVATION_RST      = 8'h20;

	// clipping arithmetic width and row coordinate width
	localparam int COORD_W = 18;
	localparam int Y_W     = 12;

	// sequence steps: area runs 0..18, full runs 15..18
	localparam int          STEP_W          = 5;
	localparam logic [4:0]  STEP_FULL_FIRST = 5'd15;
	localparam logic [4:0]  STEP_LAST       = 5'd18;

	localparam int          REQ_QUEUE_DEPTH = 2;
	localparam int          REQ_PTR_W       = 1;
	localparam int          REQ_CNT_W       = 2;

	typedef struct packed {
		logic           is_area;
		logic [7:0]     xs_byte;
		logic [7:0]     xe_byte;
		logic [Y_W-1:0] ys;
		logic [Y_W-1:0] ye;
	} req_t;

	typedef struct packed {
		logic        panel_ready;
		logic        force_full;
		logic [15:0] full_timeout;
		logic [15:0] partial_timeout;
		logic [7:0]  update_cmd;
		logic [7:0]  activation_cmd;
	} cfg_t;

endpackage

@@ hdl/ewr_front.sv @@
// ----------------------------------------------------------------------------
// ewr_front
// Takes refresh requests, clips area rectangles to the panel and widens them
// to byte columns, and hands full/area descriptors to the request queue.
// ----------------------------------------------------------------------------
module ewr_front import ewr_pkg::*; #(
	parameter int PANEL_WIDTH  = 200,
	parameter int PANEL_HEIGHT = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic signed [15:0] left,
	input  logic signed [15:0] top,
	input  logic signed [15:0] width,
	input  logic signed [15:0] height,
	input  cfg_t               cfg,
	output logic               req_valid,
	output req_t               req,
	input  logic               req_ready
);

	localparam logic signed [COORD_W-1:0] PW_S = COORD_W'(PANEL_WIDTH);
	localparam logic signed [COORD_W-1:0] PH_S = COORD_W'(PANEL_HEIGHT);
	localparam logic [COORD_W-1:0]        ONE  = COORD_W'(1);

	logic               valid_s1;
	logic               op_s1;
	logic signed [15:0] left_s1, top_s1, width_s1, height_s1;

	logic signed [COORD_W-1:0] x_s, y_s, w_s, h_s;
	logic signed [COORD_W-1:0] x1, y1, w1, h1, x_sum, y_sum;
	logic                      x_clip, y_clip, x_empty, y_empty;
	logic [COORD_W-1:0]        x_end, y_end, x_last, y_last;
	logic                      is_area, drop, s1_leave, accept;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_leave) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			left_s1   <= left;
			top_s1    <= top;
			width_s1  <= width;
			height_s1 <= height;
		end
	end

	always_comb begin
		x_s = {{(COORD_W-16){left_s1[15]}}, left_s1};
		y_s = {{(COORD_W-16){top_s1[15]}}, top_s1};
		w_s = {{(COORD_W-16){width_s1[15]}}, width_s1};
		h_s = {{(COORD_W-16){height_s1[15]}}, height_s1};

		// cut off the part left of column 0 / above row 0
		x1 = left_s1[15] ? '0 : x_s;
		w1 = left_s1[15] ? w_s + x_s : w_s;
		y1 = top_s1[15] ? '0 : y_s;
		h1 = top_s1[15] ? h_s + y_s : h_s;

		x_sum = x1 + w1;
		y_sum = y1 + h1;
		x_clip = x_sum >= PW_S;
		y_clip = y_sum >= PH_S;

		// after clipping to the edge the extent is edge - origin
		x_empty = x_clip ? (x1 >= PW_S) : (w1[COORD_W-1] || (w1 == '0));
		y_empty = y_clip ? (y1 >= PH_S) : (h1[COORD_W-1] || (h1 == '0));

		x_end  = x_clip ? PW_S : x_sum;
		y_end  = y_clip ? PH_S : y_sum;
		// byte widening: last column byte is (end - 1) / 8
		x_last = x_end - ONE;
		y_last = y_end - ONE;

		is_area = op_s1 && !cfg.force_full;
		drop    = !cfg.panel_ready || (is_area && (x_empty || y_empty));

		req.is_area = is_area;
		req.xs_byte = x1[10:3];
		req.xe_byte = x_last[10:3];
		req.ys      = y1[Y_W-1:0];
		req.ye      = y_last[Y_W-1:0];
	end

	assign req_valid = valid_s1 && !drop;
	assign s1_leave  = valid_s1 && (drop || req_ready);
	assign full      = valid_s1 && !s1_leave;

endmodule

@@ hdl/ewr_req_queue.sv @@
// ----------------------------------------------------------------------------
// ewr_req_queue
// Short queue of refresh descriptors between the front and back parts.
// ----------------------------------------------------------------------------
module ewr_req_queue import ewr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_data
);

	localparam logic [REQ_CNT_W-1:0] DEPTH_C = REQ_CNT_W'(REQ_QUEUE_DEPTH);

	req_t                 entry_q [REQ_QUEUE_DEPTH];
	logic [REQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [REQ_CNT_W-1:0] count_q;
	logic                 wr_en, rd_en;

	assign in_ready  = count_q != DEPTH_C;
	assign out_valid = count_q != '0;
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

@@ hdl/ewr_back.sv @@
// ----------------------------------------------------------------------------
// ewr_back
// Steps through the command sequence of the head descriptor into the result
// register, one link item per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module ewr_back import ewr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  req_t        req,
	output logic        req_ready,
	input  cfg_t        cfg,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic [15:0] wait_limit_ms,
	output logic        last
);

	logic [STEP_W-1:0] step_q, cur_step;
	logic              out_valid_q;
	kind_t             kind_q, kind_d;
	logic [7:0]        byte_q, byte_d;
	logic [15:0]       wait_q, wait_d;
	logic              last_q, last_d;
	logic              advance;

	assign advance   = req_valid && (!out_valid_q || pop);
	// full sequence is the tail of the area sequence
	assign cur_step  = req.is_area ? step_q : step_q + STEP_FULL_FIRST;
	assign last_d    = cur_step == STEP_LAST;
	assign req_ready = advance && last_d;

	always_comb begin
		kind_d = KIND_DATA;
		byte_d = '0;
		wait_d = '0;
		unique case (cur_step)
			5'd0:  begin kind_d = KIND_CMD; byte_d = CMD_ENTRY_MODE; end
			5'd1:  byte_d = ENTRY_XY_INC;
			5'd2:  begin kind_d = KIND_CMD; byte_d = CMD_RAM_X_WINDOW; end
			5'd3:  byte_d = req.xs_byte;
			5'd4:  byte_d = req.xe_byte;
			5'd5:  begin kind_d = KIND_CMD; byte_d = CMD_RAM_Y_WINDOW; end
			5'd6:  byte_d = req.ys[7:0];
			5'd7:  byte_d = 8'(req.ys >> 8);
			5'd8:  byte_d = req.ye[7:0];
			5'd9:  byte_d = 8'(req.ye >> 8);
			5'd10: begin kind_d = KIND_CMD; byte_d = CMD_RAM_X_PTR; end
			5'd11: byte_d = req.xs_byte;
			5'd12: begin kind_d = KIND_CMD; byte_d = CMD_RAM_Y_PTR; end
			5'd13: byte_d = req.ys[7:0];
			5'd14: byte_d = 8'(req.ys >> 8);
			5'd15: begin kind_d = KIND_CMD; byte_d = cfg.update_cmd; end
			5'd16: byte_d = req.is_area ? UPDATE_PARTIAL : UPDATE_FULL;
			5'd17: begin kind_d = KIND_CMD; byte_d = cfg.activation_cmd; end
			5'd18: begin
				kind_d = KIND_WAIT;
				wait_d = req.is_area ? cfg.partial_timeout : cfg.full_timeout;
			end
			default: begin kind_d = KIND_CMD; byte_d = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= last_d ? '0 : step_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			wait_q <= wait_d;
			last_q <= last_d;
		end
	end

	assign empty         = !out_valid_q;
	assign kind          = kind_q;
	assign byte_value    = byte_q;
	assign wait_limit_ms = wait_q;
	assign last          = last_q;

	// a sequence in progress keeps its descriptor at the queue head
	a_step_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != '0 |-> req_valid)
		else $error("sequence step advanced without a descriptor");

	a_last_is_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> kind_q == KIND_WAIT)
		else $error("last flag on an item that is not a busy wait");

	a_done_resets_step: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |=> step_q == '0)
		else $error("step counter not cleared after sequence end");

endmodule

@@ hdl/epaper_window_refresh_sequencer_top.sv @@
// A request passes the front register, request queue and back result register
// before its first link item appears. One link item per cycle while popped;
// area requests run all steps, full ones only the tail; drops stay in the front.
// The sequencer step counter sets the rate; a 2-deep request queue lets the
// front take the next request while the current one is emitted.
// Reset clears control state and loads register reset values; no clearing pass.
// ----------------------------------------------------------------------------
// epaper_window_refresh_sequencer_top
// Turns full/area refresh requests into panel command, data and busy-wait
// items, with an APB register port for panel state, timeouts and command bytes.
// ----------------------------------------------------------------------------
module epaper_window_refresh_sequencer_top import ewr_pkg::*; #(
	parameter int PANEL_WIDTH  = 200,
	parameter int PANEL_HEIGHT = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic               op,
	input  logic signed [15:0] left,
	input  logic signed [15:0] top,
	input  logic signed [15:0] width,
	input  logic signed [15:0] height,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         kind,
	output logic [7:0]         byte_value,
	output logic [15:0]        wait_limit_ms,
	output logic               last
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     reg_wr;
	logic     fq_valid, fq_ready, bq_valid, bq_ready;
	req_t     fq_data, bq_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_ready     <= 1'b0;
			cfg_q.force_full      <= 1'b0;
			cfg_q.full_timeout    <= FULL_TIMEOUT_RST;
			cfg_q.partial_timeout <= PARTIAL_TIMEOUT_RST;
			cfg_q.update_cmd      <= UPDATE_CTRL_RST;
			cfg_q.activation_cmd  <= ACTIVATION_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_PANEL_READY:     cfg_q.panel_ready     <= pwdata[0];
				REG_FORCE_FULL:      cfg_q.force_full      <= pwdata[0];
				REG_FULL_TIMEOUT:    cfg_q.full_timeout    <= pwdata[15:0];
				REG_PARTIAL_TIMEOUT: cfg_q.partial_timeout <= pwdata[15:0];
				REG_UPDATE_CTRL:     cfg_q.update_cmd      <= pwdata[7:0];
				REG_ACTIVATION:      cfg_q.activation_cmd  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_PANEL_READY:     prdata = {31'd0, cfg_q.panel_ready};
			REG_FORCE_FULL:      prdata = {31'd0, cfg_q.force_full};
			REG_FULL_TIMEOUT:    prdata = {16'd0, cfg_q.full_timeout};
			REG_PARTIAL_TIMEOUT: prdata = {16'd0, cfg_q.partial_timeout};
			REG_UPDATE_CTRL:     prdata = {24'd0, cfg_q.update_cmd};
			REG_ACTIVATION:      prdata = {24'd0, cfg_q.activation_cmd};
			default:             prdata = '0;
		endcase
	end

	ewr_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.left      (left),
		.top       (top),
		.width     (width),
		.height    (height),
		.cfg       (cfg_q),
		.req_valid (fq_valid),
		.req       (fq_data),
		.req_ready (fq_ready)
	);

	ewr_req_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_data  (bq_data)
	);

	ewr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (bq_valid),
		.req           (bq_data),
		.req_ready     (bq_ready),
		.cfg           (cfg_q),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.byte_value    (byte_value),
		.wait_limit_ms (wait_limit_ms),
		.last          (last)
	);

endmodule
